/* sv/solenoid_kicker_circuit_model_top_assert.svh */
// ----------------------------------------------------------------------------
// Kicker model assertion macros
// Immediate-cycle and next-cycle implication checks under active-low reset.
// ----------------------------------------------------------------------------
`ifndef SOLENOID_KICKER_CIRCUIT_MODEL_TOP_ASSERT_SVH
`define SOLENOID_KICKER_CIRCUIT_MODEL_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SKC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/skc_pkg.sv */
// ----------------------------------------------------------------------------
// Kicker model package
// Widths, physical divisors, register indexes and the arithmetic unit bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

    localparam int MAX_SUBSTEPS = 16;
    localparam int SUBSTEP_US   = 50;
    localparam int N_W          = $clog2(MAX_SUBSTEPS + 1);

    // shared multiply-divide unit operand widths
    localparam int A_W   = 64;
    localparam int B_W   = 32;
    localparam int D_W   = 40;
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(P_W);

    localparam int STEP_W = 27;   // ns per step, full tick register range

    localparam longint LEAK_RC_US  = 64'd20000000000;
    localparam longint COIL_L_DIV  = 64'd80000000;
    localparam longint CAP_DIV     = 64'd20000000;
    localparam longint MASS_DIV    = 64'd15000000;
    localparam longint POS_DIV     = 64'd1000000;
    localparam longint BUS_MAX_UV  = 64'd65535000;
    localparam longint COIL_MAX_UA = 64'd2147483647;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TGT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_NOMINAL  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_LIMIT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_DECAY = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_GAIN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STROKE_UM    = 4'd7;

    localparam logic [16:0] RST_TICK_US   = 17'd1000;
    localparam logic [15:0] RST_TARGET_MV = 16'd48000;
    localparam logic [15:0] RST_NOM_MV    = 16'd16000;
    localparam logic [15:0] RST_BOOST_MA  = 16'd5000;
    localparam logic [15:0] RST_DECAY     = 16'd63917;
    localparam logic [11:0] RST_FORCE     = 12'd900;
    localparam logic [15:0] RST_SPRING    = 16'd300;
    localparam logic [15:0] RST_STROKE    = 16'd8000;
    localparam logic signed [31:0] RST_BUS_UV = 32'sd16000000;

    // trunc(a * b / d), a signed, b and d unsigned, d nonzero
    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic [B_W-1:0]        b;
        logic [D_W-1:0]        d;
    } t_md_req;

    typedef struct packed {
        logic                  done;
        logic signed [A_W-1:0] q;
    } t_md_rsp;

endpackage

`default_nettype wire

/* sv/skc_in_if.sv */
// ----------------------------------------------------------------------------
// Kicker tick input channel
// One beat per simulation tick with the two gate switch states.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_in_if;
    logic valid;
    logic ready;
    logic charge_gate;
    logic kick_gate;

    modport source (output valid, output charge_gate, output kick_gate, input ready);
    modport sink   (input valid, input charge_gate, input kick_gate, output ready);
endinterface

`default_nettype wire

/* sv/skc_out_if.sv */
// ----------------------------------------------------------------------------
// Kicker result channel
// One beat per tick with the circuit and armature state.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        cap_mv;
    logic [15:0]        bus_mv;
    logic [17:0]        coil_ma;
    logic [15:0]        armature_um;
    logic signed [16:0] armature_speed;
    logic               struck;
    logic [15:0]        strike_speed;
    logic               fault;

    modport source (output valid, output cap_mv, output bus_mv, output coil_ma,
                    output armature_um, output armature_speed, output struck,
                    output strike_speed, output fault, input ready);
    modport sink   (input valid, input cap_mv, input bus_mv, input coil_ma,
                    input armature_um, input armature_speed, input struck,
                    input strike_speed, input fault, output ready);
endinterface

`default_nettype wire

/* sv/skc_cfg_if.sv */
// ----------------------------------------------------------------------------
// Kicker configuration write channel
// Register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/skc_muldiv.sv */
// ----------------------------------------------------------------------------
// Kicker shared multiply-divide unit
// Shift-add multiply over the B_W bits of b, restoring divide giving P_W quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_muldiv import skc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_md_req i_req,
    output t_md_rsp      o_rsp
);

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } t_md_state;

    t_md_state r_state, n_state;
    logic [P_W-1:0]   r_acc, n_acc;
    logic [A_W-1:0]   r_mag, n_mag;
    logic [B_W-1:0]   r_b, n_b;
    logic [D_W-1:0]   r_d, n_d;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;

    logic [A_W-1:0] a_mag;
    logic [D_W:0]   trial;
    logic           ge;
    logic [A_W-1:0] q_mag;

    assign a_mag = i_req.a[A_W-1] ? A_W'(-i_req.a) : A_W'(i_req.a);
    assign trial = {r_rem, r_acc[P_W-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign q_mag = r_acc[A_W-1:0];

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mag   = r_mag;
        n_b     = r_b;
        n_d     = r_d;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_mag = a_mag;
                    n_neg = i_req.a[A_W-1];
                    n_b   = i_req.b;
                    n_d   = i_req.d;
                    n_cnt = '0;
                    n_rem = '0;
                    if (i_req.b == B_W'(1)) begin
                        // skip the multiply
                        n_acc   = P_W'(a_mag);
                        n_state = (i_req.d == D_W'(1)) ? MD_DONE : MD_DIV;
                    end else begin
                        n_acc   = '0;
                        n_state = MD_MUL;
                    end
                end
            end
            MD_MUL: begin
                n_acc = {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? P_W'(r_mag) : '0);
                n_b   = {r_b[B_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_d == D_W'(1)) ? MD_DONE : MD_DIV;
                end
            end
            MD_DIV: begin
                n_rem = ge ? D_W'(trial - {1'b0, r_d}) : trial[D_W-1:0];
                n_acc = {r_acc[P_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(P_W - 1)) begin
                    n_state = MD_DONE;
                end
            end
            MD_DONE: begin
                n_state = MD_IDLE;
            end
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_b   <= n_b;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_rsp.done = (r_state == MD_DONE);
    assign o_rsp.q    = r_neg ? -$signed(q_mag) : $signed(q_mag);

endmodule

`default_nettype wire

/* sv/solenoid_kicker_circuit_model_top.sv */
// ----------------------------------------------------------------------------
// Solenoid kicker circuit model
// Tick-by-tick capacitor, bus, coil and armature model on one shared
// multiply-divide unit driven by a sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  i_in     | in  | charge_gate, kick_gate: one simulation tick
//  i_cfg    | in  | index, data: one register write
//  o_res    | out | cap, bus, coil, armature, strike, fault: one tick result
//
// Every arithmetic step is trunc(a*b/d) on the shared unit: a start, a
// multiply (skipped when b is one), a divide (skipped when d is one) and a
// handoff. A tick takes about 7*n + 14 such steps, n = substeps (1..16);
// a fault tick about 12 steps. Synchronous reset, no sweep.
// i_in is ready only between ticks; the result register holds a beat until
// taken while the next tick is accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "solenoid_kicker_circuit_model_top_assert.svh"

module solenoid_kicker_circuit_model_top import skc_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    skc_in_if.sink   i_in,
    skc_cfg_if.sink  i_cfg,
    skc_out_if.source o_res
);

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_FCOIL  = 22'h000002,
        S_NSUB   = 22'h000004,
        S_SUBNS  = 22'h000008,
        S_LEAK   = 22'h000010,
        S_DECAY  = 22'h000020,
        S_AVG    = 22'h000040,
        S_LIM    = 22'h000080,
        S_LIMV   = 22'h000100,
        S_CAPSET = 22'h000200,
        S_DROP   = 22'h000400,
        S_KSET   = 22'h000800,
        S_COIL   = 22'h001000,
        S_CAPD   = 22'h002000,
        S_IMA    = 22'h004000,
        S_FG     = 22'h008000,
        S_SPR    = 22'h010000,
        S_VEL    = 22'h020000,
        S_POS    = 22'h040000,
        S_END    = 22'h080000,
        S_ODIV   = 22'h100000,
        S_DONE   = 22'h200000
    } t_state;

    // configuration
    logic [16:0] r_tick_us;
    logic [15:0] r_target_mv, r_nom_mv, r_boost_ma, r_decay, r_spring, r_stroke_um;
    logic [11:0] r_fg;

    // model state
    t_state r_state, n_state;
    logic signed [31:0] r_cap, n_cap, r_bus, n_bus, r_coil, n_coil;
    logic signed [31:0] r_pos, n_pos, r_vel, n_vel;
    logic               r_fired, n_fired;
    logic               r_hit, n_hit;
    logic signed [31:0] r_hit_vel, n_hit_vel;

    // per-tick working registers
    logic               r_cg, n_cg, r_kg, n_kg, r_run, n_run;
    logic signed [31:0] r_kept, n_kept;
    logic [N_W-1:0]     r_n, n_n, r_cnt, n_cnt;
    logic [STEP_W-1:0]  r_step, n_step;
    logic signed [63:0] r_v1, n_v1, r_avg, n_avg, r_f, n_f;
    logic [21:0]        r_ima, n_ima;
    logic [2:0]         r_oi, n_oi;

    // staged and registered results
    logic [15:0]        r_s_cap, n_s_cap, r_s_bus, n_s_bus, r_s_pos, n_s_pos;
    logic [15:0]        r_s_hit, n_s_hit;
    logic [17:0]        r_s_coil, n_s_coil;
    logic signed [16:0] r_s_vel, n_s_vel;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_o_cap, r_o_bus, r_o_pos, r_o_hit;
    logic [17:0]        r_o_coil;
    logic signed [16:0] r_o_vel;
    logic               r_o_struck, r_o_fault;

    t_md_req md_req;
    t_md_rsp md_rsp;

    skc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // derived quantities
    logic [16:0]        dt;
    logic [STEP_W-1:0]  dt_ns;
    logic [25:0]        t_uv, nom_uv, stroke_nm;
    logic [24:0]        half_uv;
    logic signed [63:0] cap64, bus64, coil64, pos64, vel64, t_uv64, nom_uv64, stroke64;
    logic signed [63:0] res;
    logic               in_beat, is_op;
    logic signed [A_W-1:0] op_a;
    logic [B_W-1:0]     op_b;
    logic [D_W-1:0]     op_d;

    assign dt        = (r_tick_us == '0) ? 17'd1 : r_tick_us;
    assign dt_ns     = STEP_W'(dt * 32'd1000);
    assign t_uv      = 26'(r_target_mv * 32'd1000);
    assign nom_uv    = 26'(r_nom_mv * 32'd1000);
    assign half_uv   = 25'(r_nom_mv * 32'd500);
    assign stroke_nm = 26'(r_stroke_um * 32'd1000);
    assign cap64     = 64'(r_cap);
    assign bus64     = 64'(r_bus);
    assign coil64    = 64'(r_coil);
    assign pos64     = 64'(r_pos);
    assign vel64     = 64'(r_vel);
    assign t_uv64    = $signed(64'(t_uv));
    assign nom_uv64  = $signed(64'(nom_uv));
    assign stroke64  = $signed(64'(stroke_nm));
    assign res       = md_rsp.q;
    assign in_beat   = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [17:0] satu(input logic signed [63:0] x,
                                         input logic signed [63:0] hi);
        if (x < 0) begin
            return '0;
        end else if (x > hi) begin
            return 18'(hi);
        end
        return x[17:0];
    endfunction

    // operand select for the shared unit
    always_comb begin
        op_a  = '0;
        op_b  = B_W'(1);
        op_d  = D_W'(1);
        is_op = 1'b1;
        unique case (r_state)
            S_FCOIL: begin
                op_a = $signed(64'(r_nom_mv));
                op_b = B_W'(5000);
                op_d = D_W'(7);
            end
            S_NSUB: begin
                op_a = $signed(64'(dt) + 64'(SUBSTEP_US - 1));
                op_d = D_W'(SUBSTEP_US);
            end
            S_SUBNS: begin
                op_a = $signed(64'(dt_ns));
                op_d = D_W'(r_n);
            end
            S_LEAK: begin
                op_a = cap64;
                op_b = B_W'(dt);
                op_d = D_W'(LEAK_RC_US);
            end
            S_DECAY: begin
                op_a = t_uv64 - cap64;
                op_b = B_W'(r_decay);
                op_d = D_W'(65536);
            end
            S_AVG: begin
                op_a = r_v1 - cap64;
                op_b = B_W'(20);
                op_d = D_W'(dt);
            end
            S_LIM: begin
                op_a = bus64;
                op_b = B_W'(r_boost_ma * 32'd85);
                op_d = D_W'(64'(t_uv) * 64'd100);
            end
            S_LIMV: begin
                op_a = r_avg;
                op_b = B_W'(dt);
                op_d = D_W'(20);
            end
            S_DROP: begin
                op_a = r_avg;
                op_b = B_W'(t_uv);
                op_d = D_W'(r_nom_mv * 32'd17);
            end
            S_COIL: begin
                op_a = cap64 * 64'sd100 - coil64 * 64'sd65;
                op_b = B_W'(r_step);
                op_d = D_W'(COIL_L_DIV);
            end
            S_CAPD: begin
                op_a = coil64;
                op_b = B_W'(r_step);
                op_d = D_W'(CAP_DIV);
            end
            S_IMA: begin
                op_a = coil64;
                op_d = D_W'(1000);
            end
            S_FG: begin
                op_a = $signed(64'({12'b0, r_ima} * {22'b0, r_fg}));
                op_b = B_W'(r_ima);
            end
            S_SPR: begin
                op_a = pos64;
                op_b = B_W'(r_spring);
                op_d = D_W'(1000);
            end
            S_VEL: begin
                op_a = r_f;
                op_b = B_W'(r_step);
                op_d = D_W'(MASS_DIV);
            end
            S_POS: begin
                op_a = vel64;
                op_b = B_W'(r_step);
                op_d = D_W'(POS_DIV);
            end
            S_ODIV: begin
                op_d = D_W'(1000);
                case (r_oi)
                    3'd0:    op_a = cap64;
                    3'd1:    op_a = bus64;
                    3'd2:    op_a = coil64;
                    3'd3:    op_a = pos64;
                    3'd4:    op_a = vel64;
                    default: op_a = 64'(r_hit_vel);
                endcase
            end
            default: is_op = 1'b0;
        endcase
    end

    assign md_req.start = is_op && !r_run;
    assign md_req.a     = op_a;
    assign md_req.b     = op_b;
    assign md_req.d     = op_d;

    // sequencer
    always_comb begin
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = pos64 + res;
        s = '0;
        n_state = r_state;
        n_cap = r_cap; n_bus = r_bus; n_coil = r_coil; n_pos = r_pos; n_vel = r_vel;
        n_fired = r_fired; n_hit = r_hit; n_hit_vel = r_hit_vel;
        n_cg = r_cg; n_kg = r_kg; n_kept = r_kept; n_n = r_n; n_cnt = r_cnt;
        n_step = r_step; n_v1 = r_v1; n_avg = r_avg; n_f = r_f; n_ima = r_ima;
        n_oi = r_oi;
        n_s_cap = r_s_cap; n_s_bus = r_s_bus; n_s_coil = r_s_coil; n_s_pos = r_s_pos;
        n_s_vel = r_s_vel; n_s_hit = r_s_hit;
        n_run = r_run;
        n_out_valid = r_out_valid && !o_res.ready;

        if (md_req.start) begin
            n_run = 1'b1;
        end
        if (md_rsp.done) begin
            n_run = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_cg      = i_in.charge_gate;
                    n_kg      = i_in.kick_gate;
                    n_hit     = 1'b0;
                    n_hit_vel = '0;
                    if (i_in.charge_gate && i_in.kick_gate) begin
                        n_bus   = $signed(32'(half_uv));
                        n_step  = dt_ns;
                        n_state = S_FCOIL;
                    end else begin
                        n_state = S_NSUB;
                    end
                end
            end
            S_FCOIL: if (md_rsp.done) begin
                n_coil  = res[31:0];
                n_state = S_IMA;
            end
            S_NSUB: if (md_rsp.done) begin
                n_n     = (res > 64'(MAX_SUBSTEPS)) ? N_W'(MAX_SUBSTEPS) : res[N_W-1:0];
                n_state = S_SUBNS;
            end
            S_SUBNS: if (md_rsp.done) begin
                n_step  = res[STEP_W-1:0];
                n_state = S_LEAK;
            end
            S_LEAK: if (md_rsp.done) begin
                s       = cap64 - res;
                n_cap   = (s < 0) ? '0 : s[31:0];
                n_state = r_cg ? S_DECAY : S_KSET;
            end
            S_DECAY: if (md_rsp.done) begin
                n_v1    = t_uv64 - res;
                n_state = S_AVG;
            end
            S_AVG: if (md_rsp.done) begin
                n_avg   = res;
                n_state = (t_uv != '0) ? S_LIM : S_CAPSET;
            end
            S_LIM: if (md_rsp.done) begin
                if (r_avg > res && res > 0) begin
                    n_avg   = res;
                    n_state = S_LIMV;
                end else begin
                    n_state = S_CAPSET;
                end
            end
            S_LIMV: if (md_rsp.done) begin
                n_v1    = cap64 + res;
                n_state = S_CAPSET;
            end
            S_CAPSET: begin
                n_cap = (r_v1 > t_uv64) ? $signed(32'(t_uv)) : r_v1[31:0];
                if (r_nom_mv == '0) begin
                    n_bus   = '0;
                    n_state = S_KSET;
                end else begin
                    n_state = S_DROP;
                end
            end
            S_DROP: if (md_rsp.done) begin
                s = nom_uv64 - res;
                if (s < 0) begin
                    n_bus = '0;
                end else if (s > BUS_MAX_UV) begin
                    n_bus = 32'(BUS_MAX_UV);
                end else begin
                    n_bus = s[31:0];
                end
                n_state = S_KSET;
            end
            S_KSET: begin
                // without the kick gate the coil runs with the capacitor out of circuit
                if (!r_kg) begin
                    n_kept = r_cap;
                    n_cap  = '0;
                end
                n_cnt   = '0;
                n_state = S_COIL;
            end
            S_COIL: if (md_rsp.done) begin
                s = coil64 + res;
                if (s < 0) begin
                    n_coil = '0;
                end else if (s > COIL_MAX_UA) begin
                    n_coil = 32'(COIL_MAX_UA);
                end else begin
                    n_coil = s[31:0];
                end
                n_state = S_CAPD;
            end
            S_CAPD: if (md_rsp.done) begin
                s       = cap64 - res;
                n_cap   = (s < 0) ? '0 : s[31:0];
                n_state = S_IMA;
            end
            S_IMA: if (md_rsp.done) begin
                n_ima   = res[21:0];
                n_state = S_FG;
            end
            S_FG: if (md_rsp.done) begin
                n_f     = res;
                n_state = S_SPR;
            end
            S_SPR: if (md_rsp.done) begin
                n_f     = r_f - res - vel64 * 64'sd5;
                n_state = S_VEL;
            end
            S_VEL: if (md_rsp.done) begin
                n_vel   = sat32(vel64 + res);
                n_state = S_POS;
            end
            S_POS: if (md_rsp.done) begin
                if (r_cg && r_kg) begin
                    if (p < 0) begin
                        n_pos = '0;
                    end else if (p > stroke64) begin
                        n_pos = $signed(32'(stroke_nm));
                    end else begin
                        n_pos = p[31:0];
                    end
                    n_oi    = '0;
                    n_state = S_ODIV;
                end else begin
                    if (p >= stroke64) begin
                        n_pos = $signed(32'(stroke_nm));
                        if (r_vel > 0 && !r_fired) begin
                            // first strike of the tick keeps its speed
                            if (!r_hit) begin
                                n_hit     = 1'b1;
                                n_hit_vel = r_vel;
                            end
                            n_fired = 1'b1;
                        end
                        if (r_vel > 0) begin
                            n_vel = '0;
                        end
                    end else if (p <= 0) begin
                        n_pos = '0;
                        if (r_vel < 0) begin
                            n_vel = '0;
                        end
                        n_fired = 1'b0;
                    end else begin
                        n_pos = p[31:0];
                    end
                    if (r_cnt == r_n - 1'b1) begin
                        n_state = S_END;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_COIL;
                    end
                end
            end
            S_END: begin
                if (!r_kg) begin
                    n_cap = r_kept;
                end
                if (!r_cg) begin
                    n_bus = $signed(32'(nom_uv));
                end
                n_oi    = '0;
                n_state = S_ODIV;
            end
            S_ODIV: if (md_rsp.done) begin
                case (r_oi)
                    3'd0: n_s_cap  = 16'(satu(res, 64'sd65535));
                    3'd1: n_s_bus  = 16'(satu(res, 64'sd65535));
                    3'd2: n_s_coil = satu(res, 64'sd262143);
                    3'd3: n_s_pos  = 16'(satu(res, 64'sd65535));
                    3'd4: begin
                        if (res > 64'sd65535) begin
                            n_s_vel = 17'sd65535;
                        end else if (res < -64'sd65536) begin
                            n_s_vel = -17'sd65536;
                        end else begin
                            n_s_vel = res[16:0];
                        end
                    end
                    default: n_s_hit = 16'(satu(res, 64'sd65535));
                endcase
                if (r_oi == 3'd5) begin
                    n_state = S_DONE;
                end else begin
                    n_oi = r_oi + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_us   <= RST_TICK_US;
            r_target_mv <= RST_TARGET_MV;
            r_nom_mv    <= RST_NOM_MV;
            r_boost_ma  <= RST_BOOST_MA;
            r_decay     <= RST_DECAY;
            r_fg        <= RST_FORCE;
            r_spring    <= RST_SPRING;
            r_stroke_um <= RST_STROKE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_TICK_US:      r_tick_us   <= i_cfg.data;
                CFG_CHARGE_TGT:   r_target_mv <= i_cfg.data[15:0];
                CFG_BUS_NOMINAL:  r_nom_mv    <= i_cfg.data[15:0];
                CFG_BOOST_LIMIT:  r_boost_ma  <= i_cfg.data[15:0];
                CFG_CHARGE_DECAY: r_decay     <= i_cfg.data[15:0];
                CFG_FORCE_GAIN:   r_fg        <= i_cfg.data[11:0];
                CFG_SPRING_GAIN:  r_spring    <= i_cfg.data[15:0];
                CFG_STROKE_UM:    r_stroke_um <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= '0;
            r_bus       <= RST_BUS_UV;
            r_coil      <= '0;
            r_pos       <= '0;
            r_vel       <= '0;
            r_fired     <= 1'b0;
            r_hit       <= 1'b0;
            r_hit_vel   <= '0;
            r_run       <= 1'b0;
            r_cnt       <= '0;
            r_n         <= N_W'(1);
            r_oi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_bus       <= n_bus;
            r_coil      <= n_coil;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
            r_fired     <= n_fired;
            r_hit       <= n_hit;
            r_hit_vel   <= n_hit_vel;
            r_run       <= n_run;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_oi        <= n_oi;
            r_out_valid <= n_out_valid;
        end
        r_cg     <= n_cg;
        r_kg     <= n_kg;
        r_kept   <= n_kept;
        r_step   <= n_step;
        r_v1     <= n_v1;
        r_avg    <= n_avg;
        r_f      <= n_f;
        r_ima    <= n_ima;
        r_s_cap  <= n_s_cap;
        r_s_bus  <= n_s_bus;
        r_s_coil <= n_s_coil;
        r_s_pos  <= n_s_pos;
        r_s_vel  <= n_s_vel;
        r_s_hit  <= n_s_hit;
        if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
            r_o_cap    <= r_s_cap;
            r_o_bus    <= r_s_bus;
            r_o_coil   <= r_s_coil;
            r_o_pos    <= r_s_pos;
            r_o_vel    <= r_s_vel;
            r_o_hit    <= r_hit ? r_s_hit : '0;
            r_o_struck <= r_hit;
            r_o_fault  <= r_cg && r_kg;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cap_mv         = r_o_cap;
    assign o_res.bus_mv         = r_o_bus;
    assign o_res.coil_ma        = r_o_coil;
    assign o_res.armature_um    = r_o_pos;
    assign o_res.armature_speed = r_o_vel;
    assign o_res.struck         = r_o_struck;
    assign o_res.strike_speed   = r_o_hit;
    assign o_res.fault          = r_o_fault;

    `SKC_ASSERT_NOW(a_idle_unit_quiet, i_clk, i_rst_n, r_state == S_IDLE, !r_run, "unit busy between ticks")
    `SKC_ASSERT_NOW(a_done_when_run, i_clk, i_rst_n, md_rsp.done, r_run, "unit finished without a request")
    `SKC_ASSERT_NOW(a_substep_range, i_clk, i_rst_n, r_state == S_COIL, r_cnt < r_n, "substep count overran")
    `SKC_ASSERT_NOW(a_coil_nonneg, i_clk, i_rst_n, 1'b1, !r_coil[31], "coil current negative")
    `SKC_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, in_beat, r_state != S_IDLE, "accepted tick not started")

endmodule

`default_nettype wire

/* bench/solenoid_kicker_circuit_model_top_tb.sv */
// ----------------------------------------------------------------------------
// Solenoid kicker circuit model testbench
// Sends tick beats with random gate states through charge, kick and relax
// sequences over several register settings, predicts each result in a
// scoreboard and compares it field by field under random idle and stall.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [15:0]        cap_mv;
    logic [15:0]        bus_mv;
    logic [17:0]        coil_ma;
    logic [15:0]        armature_um;
    logic signed [16:0] armature_speed;
    logic               struck;
    logic [15:0]        strike_speed;
    logic               fault;
} t_kick_result;

class kicker_scoreboard;
    // register copy
    longint tick_us, target_mv, nominal_mv, boost_ma, decay_q16;
    longint force_k, spring_k, stroke_um;
    // circuit state in uV, uA, nm, um/s
    longint cap_uv, bus_uv, coil_ua, pos_nm, vel_ums;
    bit     fired;
    bit     hit_now;
    longint hit_vel;
    t_kick_result expected_q[$];
    int errors;
    int ticks_noted;
    int strikes_seen;
    int faults_seen;

    function new();
        tick_us = 1000; target_mv = 48000; nominal_mv = 16000; boost_ma = 5000;
        decay_q16 = 63917; force_k = 900; spring_k = 300; stroke_um = 8000;
        cap_uv = 0; bus_uv = nominal_mv * 1000; coil_ua = 0; pos_nm = 0;
        vel_ums = 0; fired = 0; errors = 0; ticks_noted = 0;
        strikes_seen = 0; faults_seen = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [16:0] data);
        case (idx)
            skc_pkg::CFG_TICK_US:      tick_us = longint'(data);
            skc_pkg::CFG_CHARGE_TGT:   target_mv = longint'(data[15:0]);
            skc_pkg::CFG_BUS_NOMINAL:  nominal_mv = longint'(data[15:0]);
            skc_pkg::CFG_BOOST_LIMIT:  boost_ma = longint'(data[15:0]);
            skc_pkg::CFG_CHARGE_DECAY: decay_q16 = longint'(data[15:0]);
            skc_pkg::CFG_FORCE_GAIN:   force_k = longint'(data[11:0]);
            skc_pkg::CFG_SPRING_GAIN:  spring_k = longint'(data[15:0]);
            skc_pkg::CFG_STROKE_UM:    stroke_um = longint'(data[15:0]);
            default: ;
        endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // trunc(a*b/d) without overflowing the product
    function longint scale(longint a, longint b, longint d);
        longint q, r;
        q = a / d;
        r = a % d;
        return q * b + (r * b) / d;
    endfunction

    function longint net_force();
        longint ima, f;
        ima = coil_ua / 1000;
        f = force_k * ima * ima;
        f -= spring_k * pos_nm / 1000;
        f -= 5 * vel_ums;
        return f;
    endfunction

    function void advance_substep(longint sub_ns);
        longint stroke_nm;
        stroke_nm = stroke_um * 1000;
        coil_ua += scale(100 * cap_uv - 65 * coil_ua, sub_ns, skc_pkg::COIL_L_DIV);
        coil_ua = clip(coil_ua, 0, skc_pkg::COIL_MAX_UA);
        cap_uv -= scale(coil_ua, sub_ns, skc_pkg::CAP_DIV);
        if (cap_uv < 0) cap_uv = 0;
        vel_ums = clip(vel_ums + scale(net_force(), sub_ns, skc_pkg::MASS_DIV),
                       -64'sd2147483648, 64'sd2147483647);
        pos_nm += scale(vel_ums, sub_ns, skc_pkg::POS_DIV);
        if (pos_nm >= stroke_nm) begin
            pos_nm = stroke_nm;
            if (vel_ums > 0 && !fired) begin
                if (!hit_now) begin
                    hit_now = 1;
                    hit_vel = vel_ums;
                end
                fired = 1;
            end
            if (vel_ums > 0) vel_ums = 0;
        end else if (pos_nm <= 0) begin
            pos_nm = 0;
            if (vel_ums < 0) vel_ums = 0;
            fired = 0;
        end
    endfunction

    function void charge_cap(longint dt, bit charging);
        longint t_uv, v0, v1, avg, lim, drop;
        t_uv = target_mv * 1000;
        cap_uv -= cap_uv * dt / skc_pkg::LEAK_RC_US;
        if (cap_uv < 0) cap_uv = 0;
        if (!charging) return;
        v0 = cap_uv;
        v1 = t_uv - (t_uv - v0) * decay_q16 / 65536;
        avg = 20 * (v1 - v0) / dt;
        if (t_uv > 0) begin
            lim = boost_ma * bus_uv * 85 / (100 * t_uv);
            if (avg > lim && lim > 0) begin
                avg = lim;
                v1 = v0 + lim * dt / 20;
            end
        end
        if (v1 > t_uv) v1 = t_uv;
        cap_uv = v1;
        if (nominal_mv == 0) begin
            bus_uv = 0;
        end else begin
            drop = avg * t_uv / (17 * nominal_mv);
            bus_uv = clip(nominal_mv * 1000 - drop, 0, skc_pkg::BUS_MAX_UV);
        end
    endfunction

    function void note_tick(bit cg, bit kg);
        longint dt, n, sub_ns, kept, spd;
        t_kick_result r;
        dt = tick_us == 0 ? 1 : tick_us;
        hit_now = 0;
        hit_vel = 0;
        if (cg && kg) begin
            bus_uv = nominal_mv * 500;
            coil_ua = nominal_mv * 5000 / 7;
            vel_ums = clip(vel_ums + scale(net_force(), dt * 1000, skc_pkg::MASS_DIV),
                           -64'sd2147483648, 64'sd2147483647);
            pos_nm = clip(pos_nm + scale(vel_ums, dt * 1000, skc_pkg::POS_DIV),
                          0, stroke_um * 1000);
        end else begin
            n = (dt + skc_pkg::SUBSTEP_US - 1) / skc_pkg::SUBSTEP_US;
            if (n < 1) n = 1;
            if (n > skc_pkg::MAX_SUBSTEPS) n = skc_pkg::MAX_SUBSTEPS;
            sub_ns = dt * 1000 / n;
            charge_cap(dt, cg);
            if (kg) begin
                for (int i = 0; i < n; i++) advance_substep(sub_ns);
            end else begin
                // no kick: coil sees no capacitor
                kept = cap_uv;
                cap_uv = 0;
                for (int i = 0; i < n; i++) advance_substep(sub_ns);
                cap_uv = kept;
            end
            if (!cg) bus_uv = nominal_mv * 1000;
        end
        r.cap_mv = 16'(clip(cap_uv / 1000, 0, 65535));
        r.bus_mv = 16'(clip(bus_uv / 1000, 0, 65535));
        r.coil_ma = 18'(clip(coil_ua / 1000, 0, 262143));
        r.armature_um = 16'(clip(pos_nm / 1000, 0, 65535));
        spd = clip(vel_ums / 1000, -65536, 65535);
        r.armature_speed = spd[16:0];
        r.struck = hit_now;
        r.strike_speed = hit_now ? 16'(clip(hit_vel / 1000, 0, 65535)) : 16'd0;
        r.fault = cg && kg;
        expected_q.push_back(r);
        ticks_noted++;
        if (hit_now) strikes_seen++;
        if (r.fault) faults_seen++;
    endfunction

    function void check_result(t_kick_result got);
        t_kick_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat cap=%0d", $realtime, got.cap_mv);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.cap_mv !== e.cap_mv) begin
            $display("%0t: cap_mv exp %0d got %0d", $realtime, e.cap_mv, got.cap_mv);
            errors++;
        end
        if (got.bus_mv !== e.bus_mv) begin
            $display("%0t: bus_mv exp %0d got %0d", $realtime, e.bus_mv, got.bus_mv);
            errors++;
        end
        if (got.coil_ma !== e.coil_ma) begin
            $display("%0t: coil_ma exp %0d got %0d", $realtime, e.coil_ma, got.coil_ma);
            errors++;
        end
        if (got.armature_um !== e.armature_um) begin
            $display("%0t: armature_um exp %0d got %0d", $realtime, e.armature_um,
                     got.armature_um);
            errors++;
        end
        if (got.armature_speed !== e.armature_speed) begin
            $display("%0t: armature_speed exp %0d got %0d", $realtime,
                     e.armature_speed, got.armature_speed);
            errors++;
        end
        if (got.struck !== e.struck) begin
            $display("%0t: struck exp %0d got %0d", $realtime, e.struck, got.struck);
            errors++;
        end
        if (got.strike_speed !== e.strike_speed) begin
            $display("%0t: strike_speed exp %0d got %0d", $realtime, e.strike_speed,
                     got.strike_speed);
            errors++;
        end
        if (got.fault !== e.fault) begin
            $display("%0t: fault exp %0d got %0d", $realtime, e.fault, got.fault);
            errors++;
        end
    endfunction
endclass

module solenoid_kicker_circuit_model_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skc_pkg::*;

    localparam logic [3:0] CFG_UNMAPPED = 4'd9;
    localparam int STALL_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    skc_in_if  tick_ch();
    skc_cfg_if cfg_ch();
    skc_out_if res_ch();

    solenoid_kicker_circuit_model_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (tick_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    kicker_scoreboard kick_sb = new();
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    always #1 i_clk = ~i_clk;

    // check then pick next ready; both see pre-edge values
    always @(posedge i_clk) begin
        t_kick_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.cap_mv = res_ch.cap_mv;
            got.bus_mv = res_ch.bus_mv;
            got.coil_ma = res_ch.coil_ma;
            got.armature_um = res_ch.armature_um;
            got.armature_speed = res_ch.armature_speed;
            got.struck = res_ch.struck;
            got.strike_speed = res_ch.strike_speed;
            got.fault = res_ch.fault;
            kick_sb.check_result(got);
        end
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("[solenoid_kicker_circuit_model_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(bit cg, bit kg);
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.charge_gate <= cg;
        tick_ch.kick_gate <= kg;
        do @(posedge i_clk); while (!tick_ch.ready);
        kick_sb.note_tick(cg, kg);
        items_sent++;
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (kick_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [16:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        kick_sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(int tick, int tgt, int nom, int boost, int decay,
                             int frc, int spr, int strk);
        write_reg(CFG_TICK_US, 17'(tick));
        write_reg(CFG_CHARGE_TGT, 17'(tgt));
        write_reg(CFG_BUS_NOMINAL, 17'(nom));
        write_reg(CFG_BOOST_LIMIT, 17'(boost));
        write_reg(CFG_CHARGE_DECAY, 17'(decay));
        write_reg(CFG_FORCE_GAIN, 17'(frc));
        write_reg(CFG_SPRING_GAIN, 17'(spr));
        write_reg(CFG_STROKE_UM, 17'(strk));
    endtask

    // mostly charge, kick, relax strokes with random lengths; some noise
    task automatic run_strokes(int count, bit pause_midway);
        int done_here;
        int n_chg, n_kick, n_relax, n_noise;
        done_here = 0;
        while (done_here < count) begin
            if (pause_midway && done_here >= count / 2) begin
                drain();
                pause_midway = 0;
            end
            if ($urandom_range(99) < 75) begin
                n_chg = int'($urandom_range(6, 1));
                n_kick = int'($urandom_range(6, 1));
                n_relax = int'($urandom_range(4, 0));
                repeat (n_chg) send_tick(1'b1, 1'b0);
                repeat (n_kick) send_tick(1'b0, 1'b1);
                repeat (n_relax) send_tick(1'b0, 1'b0);
                done_here += n_chg + n_kick + n_relax;
            end else begin
                n_noise = int'($urandom_range(3, 1));
                repeat (n_noise) begin
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                    done_here++;
                end
            end
        end
        drain();
    endtask

    initial begin
        tick_ch.valid = 1'b0;
        tick_ch.charge_gate = 1'b0;
        tick_ch.kick_gate = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every gate combination
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        drain();

        // instant full charge, long tick at the substep cap, masked force gain, unmapped index
        load_regs(100000, 65535, 65535, 65535, 0, 17'h1FFFF, 0, 65535);
        write_reg(CFG_UNMAPPED, 17'h1FFFF);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        drain();

        // zero tick, zero target, zero nominal bus, two substeps
        load_regs(0, 0, 0, 0, 65535, 4095, 65535, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        drain();
        write_reg(CFG_TICK_US, 17'd51);
        write_reg(CFG_CHARGE_TGT, 17'd30000);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        drain();

        // random phases: no idle, sender idle, sink stall, both
        load_regs(20, 40000, 24000, 65535, 0, 4095, 300, 2000);
        run_strokes(250, 1'b0);

        sender_idle_pct = 68;
        load_regs(45, 10000, 12000, 3000, 60000, 900, 2000, 4000);
        run_strokes(250, 1'b1);

        sender_idle_pct = 0;
        sink_stall_pct = 68;
        load_regs(0, 65535, 65535, 65535, 65535, 0, 0, 65535);
        run_strokes(250, 1'b0);

        sender_idle_pct = 17;
        sink_stall_pct = 17;
        load_regs(50, 48000, 16000, 20000, 30000, 2500, 300, 1000);
        run_strokes(250, 1'b0);

        $display("ticks %0d sent, %0d checked, faults %0d, strikes %0d",
                 items_sent, kick_sb.ticks_noted, kick_sb.faults_seen,
                 kick_sb.strikes_seen);
        $display("reset, corner and four random-phase register sets, mismatches %0d",
                 kick_sb.errors);
        if (kick_sb.errors == 0 && kick_sb.expected_q.size() == 0)
            $display("[solenoid_kicker_circuit_model_top] OK");
        else
            $display("[solenoid_kicker_circuit_model_top] ERROR");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/skc_pkg.sv
sv/skc_in_if.sv
sv/skc_out_if.sv
sv/skc_cfg_if.sv
sv/skc_muldiv.sv
sv/solenoid_kicker_circuit_model_top.sv
bench/solenoid_kicker_circuit_model_top_tb.sv
